[src/rv32d_pkg.sv]
// Shared types and codes for the partial RV32IM decoder.
// No dependencies; imported by rv32d_decode and rv32im_partial_decoder_top.

package rv32d_pkg;

	// major opcodes
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;

	// funct7 values
	localparam logic [6:0] F7_BASE   = 7'b0000000;
	localparam logic [6:0] F7_ALT    = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	// funct3 values that decode specially
	localparam logic [2:0] F3_ADD   = 3'd0;
	localparam logic [2:0] F3_SLL   = 3'd1;
	localparam logic [2:0] F3_BR_R2 = 3'd2;
	localparam logic [2:0] F3_BR_R3 = 3'd3;
	localparam logic [2:0] F3_SRL   = 3'd5;

	// functional units
	localparam logic [2:0] UNIT_NONE = 3'd0;
	localparam logic [2:0] UNIT_ALU  = 3'd1;
	localparam logic [2:0] UNIT_BRU  = 3'd2;
	localparam logic [2:0] UNIT_CSR  = 3'd3;
	localparam logic [2:0] UNIT_MUL  = 3'd4;
	localparam logic [2:0] UNIT_DIV  = 3'd5;

	// ALU sub-operations
	localparam logic [3:0] ALU_ADD  = 4'd0;
	localparam logic [3:0] ALU_SUB  = 4'd1;
	localparam logic [3:0] ALU_SLL  = 4'd2;
	localparam logic [3:0] ALU_SLT  = 4'd3;
	localparam logic [3:0] ALU_LTU  = 4'd4;
	localparam logic [3:0] ALU_XOR  = 4'd5;
	localparam logic [3:0] ALU_SRL  = 4'd6;
	localparam logic [3:0] ALU_SRA  = 4'd7;
	localparam logic [3:0] ALU_OR   = 4'd8;
	localparam logic [3:0] ALU_AND  = 4'd9;

	// branch sub-operations
	localparam logic [3:0] BR_BEQ  = 4'd0;
	localparam logic [3:0] BR_BNE  = 4'd1;
	localparam logic [3:0] BR_BLT  = 4'd2;
	localparam logic [3:0] BR_BGE  = 4'd3;
	localparam logic [3:0] BR_BLTU = 4'd4;
	localparam logic [3:0] BR_BGEU = 4'd5;
	localparam logic [3:0] BR_JAL  = 4'd6;

	localparam int OUT_BITS  = 52;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int OUT_W     = OUT_BYTES * 8;

	typedef struct packed {
		logic               illegal;
		logic               control_flow;
		logic               operand_b_ready;
		logic signed [11:0] operand_b_const;
		logic               operand_a_ready;
		logic        [4:0]  operand_a_const;
		logic signed [20:0] immediate;
		logic               writes_rd;
		logic               uses_rs2;
		logic               uses_rs1;
		logic        [3:0]  sub_op;
		logic        [2:0]  unit;
	} decode_t;

	// ALU sub-op for a register or immediate form with base funct7
	function automatic logic [3:0] alu_base_op(input logic [2:0] f3);
		logic [3:0] op;
		unique case (f3)
			3'd0: op = ALU_ADD;
			3'd1: op = ALU_SLL;
			3'd2: op = ALU_SLT;
			3'd3: op = ALU_LTU;
			3'd4: op = ALU_XOR;
			3'd5: op = ALU_SRL;
			3'd6: op = ALU_OR;
			3'd7: op = ALU_AND;
			default: op = ALU_ADD;
		endcase
		return op;
	endfunction

endpackage

[src/rv32d_decode.sv]
// Combinational decode of one instruction word into a control record.
// Depends on rv32d_pkg for opcodes, unit and sub-op codes and decode_t.

module rv32d_decode (
	input  logic [31:0]           instruction,
	output rv32d_pkg::decode_t    rec
);
	import rv32d_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [11:0] iimm;

	assign opc  = instruction[6:0];
	assign f3   = instruction[14:12];
	assign f7   = instruction[31:25];
	assign iimm = instruction[31:20];

	always_comb begin
		rec = '0;
		unique case (opc)
			OPC_SYSTEM: begin
				rec.unit = UNIT_CSR;
				// immediate CSR forms take zimm from the rs1 field
				if (f3[2]) begin
					rec.operand_a_const = instruction[19:15];
					rec.operand_a_ready = 1'b1;
				end else begin
					rec.uses_rs1 = 1'b1;
				end
				rec.immediate = {9'b0, iimm};
			end
			OPC_BRANCH: begin
				rec.unit         = UNIT_BRU;
				rec.immediate    = {{8{instruction[31]}}, instruction[31], instruction[7],
					instruction[30:25], instruction[11:8], 1'b0};
				rec.uses_rs1     = 1'b1;
				rec.uses_rs2     = 1'b1;
				rec.control_flow = 1'b1;
				unique case (f3)
					3'd0: rec.sub_op = BR_BEQ;
					3'd1: rec.sub_op = BR_BNE;
					F3_BR_R2, F3_BR_R3: rec.illegal = 1'b1;
					3'd4: rec.sub_op = BR_BLT;
					3'd5: rec.sub_op = BR_BGE;
					3'd6: rec.sub_op = BR_BLTU;
					3'd7: rec.sub_op = BR_BGEU;
					default: rec.illegal = 1'b1;
				endcase
			end
			OPC_JAL: begin
				rec.unit         = UNIT_BRU;
				rec.sub_op       = BR_JAL;
				rec.immediate    = {instruction[31], instruction[19:12], instruction[20],
					instruction[30:21], 1'b0};
				rec.control_flow = 1'b1;
				rec.writes_rd    = 1'b1;
			end
			OPC_OP: begin
				rec.uses_rs1  = 1'b1;
				rec.uses_rs2  = 1'b1;
				rec.writes_rd = 1'b1;
				priority if (f7 == F7_BASE) begin
					rec.unit   = UNIT_ALU;
					rec.sub_op = alu_base_op(f3);
				end else if (f7 == F7_ALT) begin
					rec.unit = UNIT_ALU;
					priority if (f3 == F3_ADD) begin
						rec.sub_op = ALU_SUB;
					end else if (f3 == F3_SRL) begin
						rec.sub_op = ALU_SRA;
					end else begin
						rec.illegal = 1'b1;
					end
				end else if (f7 == F7_MULDIV) begin
					rec.unit   = f3[2] ? UNIT_DIV : UNIT_MUL;
					rec.sub_op = {2'b0, f3[1:0]};
				end else begin
					rec.illegal = 1'b1;
				end
			end
			OPC_OPIMM: begin
				rec.unit            = UNIT_ALU;
				rec.uses_rs1        = 1'b1;
				rec.writes_rd       = 1'b1;
				rec.immediate       = {{9{iimm[11]}}, iimm};
				rec.operand_b_const = iimm;
				rec.operand_b_ready = 1'b1;
				priority if (f3 == F3_SLL) begin
					rec.operand_b_const = {7'b0, instruction[24:20]};
					if (f7 == F7_BASE) begin
						rec.sub_op = ALU_SLL;
					end else begin
						rec.illegal = 1'b1;
					end
				end else if (f3 == F3_SRL) begin
					rec.operand_b_const = {7'b0, instruction[24:20]};
					priority if (f7 == F7_BASE) begin
						rec.sub_op = ALU_SRL;
					end else if (f7 == F7_ALT) begin
						rec.sub_op = ALU_SRA;
					end else begin
						rec.illegal = 1'b1;
					end
				end else begin
					rec.sub_op = alu_base_op(f3);
				end
			end
			default: begin
				rec.illegal = 1'b1;
			end
		endcase
	end

endmodule

[src/rv32im_partial_decoder_top.sv]
// Top level of the partial RV32IM decoder: input register, decode, result register.
// Depends on rv32d_pkg and rv32d_decode.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one 32-bit instruction word per handshake.
//   m_tvalid/m_tready/m_tdata carry one decoded control record per word.
//   A word accepted on s_tdata passes through the input register, the decode logic
//   and then the result register before it appears on m_tdata.
//   Throughput: one word per cycle while m_tready is high, set by the single
//   decode pass between the registers; a stage advances if empty or the next does.
//   Stall: when m_tready is low with a record waiting, the result register
//   holds; the input register still takes a word if it is empty, so up to
//   two words sit in the block. s_tready drops only when both are full.
//   Reset: arst_n low clears both valid flags; no word is in flight after it.
//   Every opcode outside SYSTEM, BRANCH, JAL, OP and OP-IMM returns a record
//   that is all zero except the illegal flag.

module rv32im_partial_decoder_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] instruction

	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] unit, [6:3] sub_op, [7] uses_rs1, [8] uses_rs2, [9] writes_rd,
	// [30:10] immediate, [35:31] operand_a_const, [36] operand_a_ready,
	// [48:37] operand_b_const, [49] operand_b_ready, [50] control_flow,
	// [51] illegal, [55:52] zero
	output logic [55:0] m_tdata
);
	import rv32d_pkg::*;

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	decode_t     rec_s2;
	decode_t     rec_d;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			instr_s1 <= s_tdata;
		end
	end

	rv32d_decode u_decode (
		.instruction (instr_s1),
		.rec         (rec_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// capture only a real word so a held record stays intact
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rec_s2 <= rec_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, rec_s2};

endmodule

[tb/sv/tb_rv32im_partial_decoder_top.sv]
// Testbench for rv32im_partial_decoder_top: directed and random instruction words,
// with each decoded record checked against an in-bench decoder.
// Depends on rv32d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_rv32im_partial_decoder_top;
	import rv32d_pkg::*;

	// Expected decode records in arrival order, plus the words that produced them
	class decode_board;
		decode_t     rec_q[$];
		logic [31:0] word_q[$];
		int unsigned words_in;
		int unsigned records_out;
		int unsigned illegal_seen;
		int unsigned errors;

		function logic [3:0] alu_op_for(logic [2:0] f3);
			case (f3)
				3'd0: return ALU_ADD;
				3'd1: return ALU_SLL;
				3'd2: return ALU_SLT;
				3'd3: return ALU_LTU;
				3'd4: return ALU_XOR;
				3'd5: return ALU_SRL;
				3'd6: return ALU_OR;
				default: return ALU_AND;
			endcase
		endfunction

		function decode_t decode_word(logic [31:0] w);
			decode_t    d;
			logic [2:0] f3;
			logic [6:0] f7;
			d = '0;
			f3 = w[14:12];
			f7 = w[31:25];
			case (w[6:0])
				OPC_SYSTEM: begin
					d.unit = UNIT_CSR;
					// upper funct3 bit selects the zimm forms
					if (f3[2]) begin
						d.operand_a_const = w[19:15];
						d.operand_a_ready = 1'b1;
					end else begin
						d.uses_rs1 = 1'b1;
					end
					d.immediate = {9'd0, w[31:20]};
				end
				OPC_BRANCH: begin
					d.unit = UNIT_BRU;
					d.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
					d.uses_rs1 = 1'b1;
					d.uses_rs2 = 1'b1;
					d.control_flow = 1'b1;
					case (f3)
						3'd0: d.sub_op = BR_BEQ;
						3'd1: d.sub_op = BR_BNE;
						3'd4: d.sub_op = BR_BLT;
						3'd5: d.sub_op = BR_BGE;
						3'd6: d.sub_op = BR_BLTU;
						3'd7: d.sub_op = BR_BGEU;
						default: d.illegal = 1'b1;
					endcase
				end
				OPC_JAL: begin
					d.unit = UNIT_BRU;
					d.sub_op = BR_JAL;
					d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
					d.control_flow = 1'b1;
					d.writes_rd = 1'b1;
				end
				OPC_OP: begin
					d.uses_rs1 = 1'b1;
					d.uses_rs2 = 1'b1;
					d.writes_rd = 1'b1;
					if (f7 == F7_BASE) begin
						d.unit = UNIT_ALU;
						d.sub_op = alu_op_for(f3);
					end else if (f7 == F7_ALT) begin
						d.unit = UNIT_ALU;
						if (f3 == F3_ADD)
							d.sub_op = ALU_SUB;
						else if (f3 == F3_SRL)
							d.sub_op = ALU_SRA;
						else
							d.illegal = 1'b1;
					end else if (f7 == F7_MULDIV) begin
						d.unit = f3[2] ? UNIT_DIV : UNIT_MUL;
						d.sub_op = {2'b00, f3[1:0]};
					end else begin
						d.illegal = 1'b1;
					end
				end
				OPC_OPIMM: begin
					d.unit = UNIT_ALU;
					d.uses_rs1 = 1'b1;
					d.writes_rd = 1'b1;
					d.immediate = {{9{w[31]}}, w[31:20]};
					d.operand_b_const = w[31:20];
					d.operand_b_ready = 1'b1;
					if (f3 == F3_SLL) begin
						d.operand_b_const = {7'd0, w[24:20]};
						if (f7 == F7_BASE)
							d.sub_op = ALU_SLL;
						else
							d.illegal = 1'b1;
					end else if (f3 == F3_SRL) begin
						d.operand_b_const = {7'd0, w[24:20]};
						if (f7 == F7_BASE)
							d.sub_op = ALU_SRL;
						else if (f7 == F7_ALT)
							d.sub_op = ALU_SRA;
						else
							d.illegal = 1'b1;
					end else begin
						d.sub_op = alu_op_for(f3);
					end
				end
				default: d.illegal = 1'b1;
			endcase
			return d;
		endfunction

		function void note_word(logic [31:0] w);
			decode_t d;
			d = decode_word(w);
			rec_q.push_back(d);
			word_q.push_back(w);
			words_in++;
			if (d.illegal)
				illegal_seen++;
		endfunction

		function void compare(logic [31:0] w, string name, int want_v, int got_v);
			if (want_v != got_v) begin
				errors++;
				$display("%0t: word %h %s expected %0d actual %0d",
					$time, w, name, want_v, got_v);
			end
		endfunction

		function void check_record(logic [55:0] data);
			decode_t     want;
			decode_t     got;
			logic [31:0] w;
			if (rec_q.size() == 0) begin
				errors++;
				$display("%0t: record %h arrived with nothing expected", $time, data);
				return;
			end
			want = rec_q.pop_front();
			w = word_q.pop_front();
			got = decode_t'(data[51:0]);
			records_out++;
			compare(w, "unit", want.unit, got.unit);
			compare(w, "sub_op", want.sub_op, got.sub_op);
			compare(w, "uses_rs1", want.uses_rs1, got.uses_rs1);
			compare(w, "uses_rs2", want.uses_rs2, got.uses_rs2);
			compare(w, "writes_rd", want.writes_rd, got.writes_rd);
			compare(w, "immediate", want.immediate, got.immediate);
			compare(w, "operand_a_const", want.operand_a_const, got.operand_a_const);
			compare(w, "operand_a_ready", want.operand_a_ready, got.operand_a_ready);
			compare(w, "operand_b_const", want.operand_b_const, got.operand_b_const);
			compare(w, "operand_b_ready", want.operand_b_ready, got.operand_b_ready);
			compare(w, "control_flow", want.control_flow, got.control_flow);
			compare(w, "illegal", want.illegal, got.illegal);
			compare(w, "padding", 0, data[55:52]);
		endfunction

		function int unsigned pending();
			return rec_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	decode_board board = new();
	bit          calm;
	int unsigned hold_request;

	rv32im_partial_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// Mostly well-formed words of the decoded opcodes with random fields, some pure noise
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int unsigned pick;
		w = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			w[6:0] = OPC_SYSTEM;
		end else if (pick < 27) begin
			w[6:0] = OPC_BRANCH;
		end else if (pick < 35) begin
			w[6:0] = OPC_JAL;
		end else if (pick < 60) begin
			w[6:0] = OPC_OP;
			case ($urandom_range(0, 9))
				0, 1, 2: w[31:25] = F7_BASE;
				3, 4, 5: w[31:25] = F7_ALT;
				6, 7, 8: w[31:25] = F7_MULDIV;
				default: ;
			endcase
		end else if (pick < 88) begin
			w[6:0] = OPC_OPIMM;
			if (w[14:12] == F3_SLL || w[14:12] == F3_SRL) begin
				case ($urandom_range(0, 4))
					0, 1: w[31:25] = F7_BASE;
					2, 3: w[31:25] = F7_ALT;
					default: ;
				endcase
			end
		end
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w);
		int unsigned gap;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		board.note_word(w);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: take records and apply back-pressure
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_record(m_tdata);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				m_tready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] directed[$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		calm = 1'b0;
		hold_request = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			32'h0000_0000,                                        // unknown opcode, all zero
			32'hFFFF_FFFF,                                        // unknown opcode, all ones
			enc(7'h7F, 5'h1F, 5'h1F, 3'd1, 5'd3, OPC_SYSTEM),     // csrrw, top CSR address
			enc(7'h00, 5'h00, 5'h1F, 3'd6, 5'd4, OPC_SYSTEM),     // csrrsi, zimm 31
			enc(7'h00, 5'h00, 5'h00, 3'd0, 5'd0, OPC_SYSTEM),     // funct3 zero still CSR
			enc(7'h40, 5'd2, 5'd1, 3'd0, 5'h00, OPC_BRANCH),      // beq, most negative offset
			enc(7'h3F, 5'd2, 5'd1, 3'd7, 5'h1F, OPC_BRANCH),      // bgeu, most positive offset
			enc(7'h12, 5'd5, 5'd6, 3'd1, 5'h0A, OPC_BRANCH),      // bne
			enc(7'h05, 5'd5, 5'd6, 3'd4, 5'h15, OPC_BRANCH),      // blt
			enc(7'h55, 5'd5, 5'd6, 3'd5, 5'h03, OPC_BRANCH),      // bge
			enc(7'h21, 5'd5, 5'd6, 3'd6, 5'h11, OPC_BRANCH),      // bltu
			enc(7'h2A, 5'd7, 5'd8, F3_BR_R2, 5'h06, OPC_BRANCH),  // reserved branch funct3
			enc(7'h6B, 5'd7, 5'd8, F3_BR_R3, 5'h19, OPC_BRANCH),  // reserved branch funct3
			enc(7'h40, 5'h00, 5'h00, 3'd0, 5'd1, OPC_JAL),        // jal, most negative offset
			enc(7'h3F, 5'h1F, 5'h1F, 3'd7, 5'd1, OPC_JAL),        // jal, most positive offset
			enc(F7_ALT, 5'd3, 5'd2, 3'd0, 5'd1, OPC_OP),          // sub
			enc(F7_ALT, 5'd3, 5'd2, 3'd1, 5'd1, OPC_OP),          // alt funct7, bad funct3
			enc(F7_MULDIV, 5'd3, 5'd2, 3'd7, 5'd1, OPC_OP),       // remu
			enc(F7_MULDIV, 5'd3, 5'd2, 3'd0, 5'd1, OPC_OP),       // mul
			enc(7'h7F, 5'd3, 5'd2, 3'd0, 5'd1, OPC_OP),           // unknown funct7
			enc(7'h40, 5'h00, 5'd9, 3'd0, 5'd10, OPC_OPIMM),      // addi -2048
			enc(7'h3F, 5'h1F, 5'd9, 3'd7, 5'd10, OPC_OPIMM),      // andi 2047
			enc(F7_BASE, 5'h1F, 5'd9, F3_SLL, 5'd10, OPC_OPIMM),  // slli 31
			enc(F7_ALT, 5'd1, 5'd9, F3_SRL, 5'd10, OPC_OPIMM),    // srai
			enc(F7_ALT, 5'd4, 5'd9, F3_SLL, 5'd10, OPC_OPIMM)     // slli with bad funct7
		};
		foreach (directed[i])
			send_word(directed[i]);

		// hold the result side long enough to fill the block and stall the input
		hold_request = 60;
		repeat (12) send_word(random_word());
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			calm = (phase == 2);
			repeat (370) send_word(random_word());
			if (phase == 3)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (6) @(posedge clk);

		$display("Decoded %0d instruction words across all major opcodes and reserved forms;",
			board.words_in);
		$display("%0d records checked, %0d flagged illegal, %0d mismatches.",
			board.records_out, board.illegal_seen, board.errors);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb_rv32im_partial_decoder_top: PASS");
		end else begin
			$display("tb_rv32im_partial_decoder_top: FAIL");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d records outstanding", board.pending());
		$display("tb_rv32im_partial_decoder_top: FAIL");
		$finish;
	end

endmodule

[filelist.f]
src/rv32d_pkg.sv
src/rv32d_decode.sv
src/rv32im_partial_decoder_top.sv
tb/sv/tb_rv32im_partial_decoder_top.sv
